// ===== hdl/smta_pkg.sv =====
package smta_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int CFG_BITS       = 7;
    localparam int COUNT_BITS     = 32;
    localparam int WINDOW_MAX_DEF = 64;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] amount;
        logic                   restart;
    } in_item_t;

    typedef struct packed {
        logic                  notify;
        logic                  checked;
        logic [COUNT_BITS-1:0] alert_count;
    } out_item_t;

    typedef struct packed {
        logic upd;
        logic clr;
        logic del;
        logic flush;
    } cell_ctl_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] t;
        logic                   tle;
        logic                   vld;
    } lr_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] val;
        logic                   a;
    } rl_t;

    localparam lr_t LR_HEAD = '{t: '0, tle: 1'b1, vld: 1'b1};
    localparam rl_t RL_TAIL = '{val: '0, a: 1'b0};

endpackage

// ===== hdl/smta_ram.sv =====
module smta_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/smta_cell.sv =====
module smta_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  smta_pkg::cell_ctl_t              ctl,
    input  logic [smta_pkg::SAMPLE_BITS-1:0] x,
    input  logic [smta_pkg::SAMPLE_BITS-1:0] y,
    input  smta_pkg::lr_t                    lr_in,
    input  smta_pkg::rl_t                    rl_in,
    output smta_pkg::lr_t                    lr_out,
    output smta_pkg::rl_t                    rl_out,
    output logic [smta_pkg::SAMPLE_BITS-1:0] val
);

    import smta_pkg::*;

    logic [SAMPLE_BITS-1:0] val_reg, val_next;
    logic                   vld_reg, vld_next;
    logic                   vld_e;
    logic                   a;
    logic                   b;
    logic [SAMPLE_BITS-1:0] t;
    logic                   tle;

    always_comb
    begin
        vld_e = vld_reg & ~ctl.clr;
        a     = vld_e & (val_reg <= x);
        b     = ~ctl.del | (vld_e & (val_reg < y));
        t     = b ? val_reg : rl_in.val;
        tle   = b ? a : rl_in.a;

        val_next = val_reg;
        vld_next = vld_reg;
        if (ctl.flush)
        begin
            vld_next = 1'b0;
        end
        else if (ctl.upd)
        begin
            if (tle)
            begin
                val_next = t;
            end
            else if (lr_in.tle)
            begin
                val_next = x;
            end
            else
            begin
                val_next = lr_in.t;
            end
            vld_next = ctl.del ? vld_e : lr_in.vld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign lr_out = '{t: t, tle: tle, vld: vld_e};
    assign rl_out = '{val: val_reg, a: a};
    assign val    = val_reg;

endmodule

// ===== hdl/sliding_median_threshold_alert.sv =====
// Sliding-window median alert. Each item carries one 16-bit sample; once the
// window of window_days samples is full, the sample is flagged when it is at
// least twice the window median, and a saturating alert count is kept. The
// sorted window lives in a row of WINDOW_MAX cells that insert the new value
// and, once the window is full, delete the oldest in the same update; the
// arrival order is kept in a small RAM. After the cells update, the median
// registers reload from the cells and the history RAM's registered read
// fetches the next sample to evict; the block is busy meanwhile, so it does
// not accept a new item until that is done. A result waits in an output
// register; while it is held off, the next item is stalled. Writing
// window_days empties the window but keeps the count; no clearing pass runs
// after reset.
module sliding_median_threshold_alert #(
    parameter int WINDOW_MAX = smta_pkg::WINDOW_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  smta_pkg::in_item_t            sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output smta_pkg::out_item_t           result,
    input  logic                          cfg_we,
    input  logic [smta_pkg::CFG_BITS-1:0] cfg_data
);

    import smta_pkg::*;

    localparam int WEFF_W = $clog2(WINDOW_MAX + 1);
    localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WIDE_W = WEFF_W + 1;
    localparam int CMP_W  = (WEFF_W > CFG_BITS) ? WEFF_W : CFG_BITS;

    logic [WEFF_W-1:0]      weff_reg, weff_next;
    logic [WEFF_W-1:0]      fill_reg, fill_next;
    logic [AW-1:0]          oldest_reg, oldest_next;
    logic [COUNT_BITS-1:0]  total_reg, total_next;
    logic                   busy_reg, busy_next;
    logic                   res_valid_reg, res_valid_next;
    out_item_t              res_reg, res_next;
    logic [SAMPLE_BITS-1:0] mid_lo_reg, mid_lo_next;
    logic [SAMPLE_BITS-1:0] mid_hi_reg, mid_hi_next;

    logic                   accept;
    logic [WEFF_W-1:0]      fill_eff;
    logic                   full;
    logic [SAMPLE_BITS:0]   ref_sum;
    logic                   notify;
    logic [COUNT_BITS-1:0]  total_base;
    logic [WIDE_W-1:0]      oldest_inc;
    logic [CMP_W-1:0]       cfg_wide;
    logic [AW-1:0]          waddr;
    logic [SAMPLE_BITS-1:0] old_val;
    logic [WEFF_W-1:0]      half;
    cell_ctl_t              ctl;

    lr_t                    lr_o [WINDOW_MAX];
    rl_t                    rl_o [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];

    assign accept       = sample_valid & ~sample_stall;
    assign sample_stall = busy_reg | (res_valid_reg & result_stall);

    always_comb
    begin
        fill_eff   = sample.restart ? '0 : fill_reg;
        full       = (fill_eff == weff_reg);
        ref_sum    = {1'b0, mid_lo_reg} + {1'b0, mid_hi_reg};
        notify     = full & ({1'b0, sample.amount} >= ref_sum);
        total_base = sample.restart ? '0 : total_reg;
        oldest_inc = WIDE_W'(oldest_reg) + WIDE_W'(1);
        waddr      = full ? oldest_reg : fill_eff[AW-1:0];
        cfg_wide   = CMP_W'(cfg_data);
        ctl        = '{upd: accept, clr: sample.restart, del: full, flush: cfg_we};
    end

    always_comb
    begin
        weff_next      = weff_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        total_next     = total_reg;
        busy_next      = accept;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (cfg_we)
        begin
            if (cfg_wide == '0)
            begin
                weff_next = WEFF_W'(1);
            end
            else if (cfg_wide > CMP_W'(WINDOW_MAX))
            begin
                weff_next = WEFF_W'(WINDOW_MAX);
            end
            else
            begin
                weff_next = WEFF_W'(cfg_wide);
            end
            fill_next   = '0;
            oldest_next = '0;
        end
        else if (accept)
        begin
            if (full)
            begin
                fill_next = fill_eff;
                if (oldest_inc == WIDE_W'(weff_reg))
                begin
                    oldest_next = '0;
                end
                else
                begin
                    oldest_next = AW'(oldest_inc);
                end
            end
            else
            begin
                fill_next   = fill_eff + WEFF_W'(1);
                oldest_next = '0;
            end
            total_next = total_base;
            if (notify && (total_base != '1))
            begin
                total_next = total_base + COUNT_BITS'(1);
            end
        end

        if (accept)
        begin
            res_valid_next       = 1'b1;
            res_next.notify      = notify;
            res_next.checked     = full;
            res_next.alert_count = total_next;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        half        = weff_reg >> 1;
        mid_lo_next = '0;
        mid_hi_next = '0;
        for (int k = 0; k < WINDOW_MAX; k++)
        begin
            if (WEFF_W'(k) == half)
            begin
                mid_hi_next = mid_hi_next | cell_val[k];
            end
            if (weff_reg[0] ? (WEFF_W'(k) == half) : (WEFF_W'(k + 1) == half))
            begin
                mid_lo_next = mid_lo_next | cell_val[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weff_reg      <= WEFF_W'(1);
            fill_reg      <= '0;
            oldest_reg    <= '0;
            total_reg     <= '0;
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            weff_reg      <= weff_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            total_reg     <= total_next;
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        mid_lo_reg <= mid_lo_next;
        mid_hi_reg <= mid_hi_next;
    end

    smta_ram #(
        .WIDTH     (SAMPLE_BITS),
        .DEPTH     (WINDOW_MAX),
        .ADDR_BITS (AW)
    ) u_history (
        .clk   (clk),
        .we    (accept),
        .waddr (waddr),
        .wdata (sample.amount),
        .raddr (oldest_reg),
        .rdata (old_val)
    );

    for (genvar k = 0; k < WINDOW_MAX; k++)
    begin : g_cell
        lr_t lr_in;
        rl_t rl_in;

        if (k == 0)
        begin : g_head
            assign lr_in = LR_HEAD;
        end
        else
        begin : g_mid_l
            assign lr_in = lr_o[k-1];
        end

        if (k == WINDOW_MAX - 1)
        begin : g_tail
            assign rl_in = RL_TAIL;
        end
        else
        begin : g_mid_r
            assign rl_in = rl_o[k+1];
        end

        smta_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .x      (sample.amount),
            .y      (old_val),
            .lr_in  (lr_in),
            .rl_in  (rl_in),
            .lr_out (lr_o[k]),
            .rl_out (rl_o[k]),
            .val    (cell_val[k])
        );
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
